// ----- sv/cpp_pkg.sv -----
// Shared types and constants for the camera pose packet parser.
// No dependencies; every other file of the block imports this package.
package cpp_pkg;

    localparam int PacketBytes = 29;
    localparam int FieldCount  = 8;
    localparam int FieldBits   = 24;
    localparam int FieldBytes  = FieldCount * FieldBits / 8;
    localparam int CountBits   = 5;

    // Byte index of the checksum byte; bytes below it enter the running sum.
    localparam logic [CountBits-1:0] CsumIndex = CountBits'(PacketBytes - 1);
    localparam logic [CountBits-1:0] CountMax  = {CountBits{1'b1}};
    // First and one-past-last byte index that feed the pose fields.
    localparam logic [CountBits-1:0] FieldFirst = CountBits'(2);
    localparam logic [CountBits-1:0] FieldEnd   = CountBits'(2 + FieldBytes);

    localparam logic [7:0] CsumSeed    = 8'h40;
    localparam logic [7:0] TypeDefault = 8'hD1;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_LENGTH = 2'd1;
    localparam logic [1:0] ERR_TYPE   = 2'd2;
    localparam logic [1:0] ERR_CSUM   = 2'd3;

    // Output payload widths.
    localparam int TdataBits = 8 + FieldCount * FieldBits;
    localparam int TuserBits = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_packet;
    } t_byte_item;

    typedef struct packed {
        logic                               pose_valid;
        logic [1:0]                         error_code;
        logic [7:0]                         camera_num;
        // pan, tilt, roll, x, y, z, zoom, focus from the highest bits down
        logic [FieldCount*FieldBits-1:0]    fields;
    } t_pose_result;

endpackage

// ----- sv/cpp_in_stage.sv -----
// Input register of the camera pose packet parser: holds one byte item.
// Depends on cpp_pkg.
module cpp_in_stage
    import cpp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_byte_item i_s_item,
    input  logic       i_advance,
    output logic       o_valid,
    output t_byte_item o_item
);

    logic       r_valid;
    t_byte_item r_item;

    // Take a new item whenever the register is empty or drains this cycle.
    assign o_s_tready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= i_s_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ----- sv/cpp_core.sv -----
// Packet state of the camera pose packet parser: count, checksum, type flag
// and field assembly, plus the verdict on the last byte. Depends on cpp_pkg.
module cpp_core
    import cpp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic [7:0]   i_cfg_data,
    input  logic         i_item_valid,
    input  t_byte_item   i_item,
    input  logic         i_out_free,
    output logic         o_advance,
    output logic         o_load,
    output t_pose_result o_result
);

    logic [7:0]                      r_expected_type;
    logic [CountBits-1:0]            r_byte_count, n_byte_count;
    logic [7:0]                      r_byte_sum, n_byte_sum;
    logic                            r_type_matched, n_type_matched;
    logic [7:0]                      r_camera, n_camera;
    logic [FieldCount*FieldBits-1:0] r_fields, n_fields;
    logic [1:0]                      code;
    logic                            last;

    assign last      = i_item.end_of_packet;
    // A last byte needs room in the output register; other bytes never stall.
    assign o_advance = i_item_valid && (!last || i_out_free);
    assign o_load    = o_advance && last;

    always_comb begin
        n_byte_count   = r_byte_count;
        n_byte_sum     = r_byte_sum;
        n_type_matched = r_type_matched;
        n_camera       = r_camera;
        n_fields       = r_fields;
        if (last) begin
            n_byte_count   = '0;
            n_byte_sum     = '0;
            n_type_matched = 1'b0;
        end else begin
            if (r_byte_count < CsumIndex) begin
                n_byte_sum = r_byte_sum + i_item.data_byte;
            end
            if (r_byte_count == '0) begin
                n_type_matched = (i_item.data_byte == r_expected_type);
            end
            if (r_byte_count == CountBits'(1)) begin
                n_camera = i_item.data_byte;
            end
            // Fields are big-endian and back to back: shift the bytes through.
            if (r_byte_count >= FieldFirst && r_byte_count < FieldEnd) begin
                n_fields = {r_fields[FieldCount*FieldBits-9:0], i_item.data_byte};
            end
            if (r_byte_count != CountMax) begin
                n_byte_count = r_byte_count + CountBits'(1);
            end
        end
    end

    always_comb begin
        if (r_byte_count != CsumIndex) begin
            code = ERR_LENGTH;
        end else if (!r_type_matched) begin
            code = ERR_TYPE;
        end else if (8'(CsumSeed - r_byte_sum) != i_item.data_byte) begin
            code = ERR_CSUM;
        end else begin
            code = ERR_OK;
        end
    end

    // Zero the payload of a rejected packet.
    always_comb begin
        o_result.pose_valid = (code == ERR_OK);
        o_result.error_code = code;
        o_result.camera_num = (code == ERR_OK) ? r_camera : 8'd0;
        o_result.fields     = (code == ERR_OK) ? r_fields : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_type <= TypeDefault;
        end else if (i_cfg_valid) begin
            r_expected_type <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_byte_sum     <= '0;
            r_type_matched <= 1'b0;
        end else if (o_advance) begin
            r_byte_count   <= n_byte_count;
            r_byte_sum     <= n_byte_sum;
            r_type_matched <= n_type_matched;
        end
    end

    // Camera id and fields are fully rewritten by every accepted packet.
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_camera <= n_camera;
            r_fields <= n_fields;
        end
    end

endmodule

// ----- sv/cpp_out_stage.sv -----
// Result register of the camera pose packet parser and its stream packing.
// Depends on cpp_pkg.
module cpp_out_stage
    import cpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_pose_result         i_result,
    output logic                 o_free,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [TdataBits-1:0] o_m_tdata,
    output logic [TuserBits-1:0] o_m_tuser
);

    logic         r_valid;
    t_pose_result r_result;
    logic [FieldBits-1:0] fw [FieldCount];

    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    // Field 0 (pan) sits in the top bits of the assembled word.
    always_comb begin
        for (int k = 0; k < FieldCount; k++) begin
            fw[k] = r_result.fields[(FieldCount-1-k)*FieldBits +: FieldBits];
        end
    end

    always_comb begin
        o_m_tdata[7:0] = r_result.camera_num;
        for (int k = 0; k < FieldCount; k++) begin
            o_m_tdata[8 + k*FieldBits +: FieldBits] = fw[k];
        end
    end

    assign o_m_tuser  = {r_result.error_code, r_result.pose_valid};
    assign o_m_tvalid = r_valid;

endmodule

// ----- sv/camera_pose_packet_parser.sv -----
// Top level of the camera pose packet parser (tracking message decoder).
// Depends on cpp_pkg, cpp_in_stage, cpp_core and cpp_out_stage.
//
// Usage:
//   Slave stream: one packet byte per item in tdata[7:0], tlast on the
//   packet's last byte. Every byte is taken; the last byte produces one
//   result item on the master stream, no other byte produces any.
//   Master stream: tdata carries camera id and the eight 24-bit pose words
//   (pan, tilt, roll, x, y, z, zoom, focus); tuser carries pose_valid and
//   the error code (0 ok, 1 wrong length, 2 wrong type, 3 bad checksum).
//   A packet passes only with exactly 29 bytes, byte 0 equal to the
//   configured type and byte 28 equal to 0x40 minus the sum of bytes 0..27.
//   Rejected packets report all payload fields as zero.
//   Config channel: cfg_data is the expected type byte; always ready.
//   Write it only while no packet is in flight.
// Timing:
//   One byte per cycle sustained while each last byte finds the result register
//   free. A last byte's result is held in the result register until the receiver takes it.
// Reset: synchronous, active low; drops any partial packet and pending
//   result and sets the expected type to 0xD1.
// Stall: while the result register is full and not taken, the next last
//   byte waits in the input register; bytes ahead of it keep flowing.
module camera_pose_packet_parser
    import cpp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [7:0]           i_s_axis_tdata,  // [7:0] data_byte
    input  logic                 i_s_axis_tlast,  // end_of_packet
    // master stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [7:0] camera_num, [31:8] pan_angle, [55:32] tilt_angle,
    // [79:56] roll_angle, [103:80] pos_x, [127:104] pos_y,
    // [151:128] pos_z, [175:152] zoom_value, [199:176] focus_value
    output logic [TdataBits-1:0] o_m_axis_tdata,
    output logic [TuserBits-1:0] o_m_axis_tuser,  // [0] pose_valid, [2:1] error_code
    // configuration
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_data       // expected_type
);

    t_byte_item   s_item;
    t_byte_item   held_item;
    t_pose_result result;
    logic         held_valid;
    logic         advance;
    logic         load;
    logic         out_free;

    assign s_item.data_byte     = i_s_axis_tdata;
    assign s_item.end_of_packet = i_s_axis_tlast;
    assign o_cfg_ready          = 1'b1;

    // Hold the incoming byte until the core takes it.
    cpp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_item   (s_item),
        .i_advance  (advance),
        .o_valid    (held_valid),
        .o_item     (held_item)
    );

    // Advance packet state and judge the packet on its last byte.
    cpp_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (held_valid),
        .i_item       (held_item),
        .i_out_free   (out_free),
        .o_advance    (advance),
        .o_load       (load),
        .o_result     (result)
    );

    // Hold the verdict until the receiver takes it.
    cpp_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_result   (result),
        .o_free     (out_free),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

    // pose_valid agrees with the error code.
    a_valid_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser[0] == (o_m_axis_tuser[2:1] == ERR_OK)))
        else $error("pose_valid disagrees with error code");

    // A rejected packet carries an all-zero payload.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("rejected packet with nonzero payload");

    // A result is loaded only from a held last byte that is consumed.
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (held_valid && held_item.end_of_packet && out_free))
        else $error("result loaded without a consumed last byte");

    // A held byte that does not advance blocks the slave side.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && !advance) |-> !o_s_axis_tready)
        else $error("input accepted while holding a stalled byte");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for camera_pose_packet_parser: byte stream in, pose items out.
// Depends on cpp_pkg and the RTL of the block; it reads nothing else.
module tb
    import cpp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdlePctBusy  = 35;
    localparam int HoldCycles   = 400;
    localparam int QuietLimit   = 3000;
    localparam int SettleCycles = 4;

    typedef struct packed {
        logic               pose_valid;
        logic [1:0]         error_code;
        logic [7:0]         camera_num;
        logic [7:0][23:0]   words;      // pan, tilt, roll, x, y, z, zoom, focus
    } t_pose_expect;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [7:0]           s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic                 m_tready = 1'b0;
    logic [TdataBits-1:0] o_m_axis_tdata;
    logic [TuserBits-1:0] o_m_axis_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [7:0]           cfg_data = '0;

    // bytes waiting to be offered, and pose items still owed by the block
    t_byte_item   byte_q [$];
    t_pose_expect pose_expect_q [$];

    int idle_pct = IdlePctBusy;
    int hold_req = 0;
    int fail_count = 0;
    int result_count = 0;

    // shadow of the parser: register and partial packet
    logic [7:0]         type_cfg = TypeDefault;
    logic [4:0]         pkt_count = '0;
    logic [7:0]         pkt_sum = '0;
    logic               pkt_type_ok = 1'b0;
    logic [7:0]         pkt_camera = '0;
    logic [7:0][23:0]   pkt_words = '0;

    string word_name [0:7] = '{"pan_angle", "tilt_angle", "roll_angle", "pos_x",
                               "pos_y", "pos_z", "zoom_value", "focus_value"};

    camera_pose_packet_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advance the shadow parser by one accepted byte; owe a pose item on the last byte.
    task automatic track_packet_byte(input logic [7:0] b, input logic eop);
        t_pose_expect want;
        int idx;
        int w;
        idx = int'(pkt_count);
        if (!eop) begin
            if (pkt_count < CsumIndex) pkt_sum = pkt_sum + b;
            if (idx == 0) begin
                pkt_type_ok = (b == type_cfg);
            end else if (idx == 1) begin
                pkt_camera = b;
            end else if (pkt_count >= FieldFirst && pkt_count < FieldEnd) begin
                w = (idx - int'(FieldFirst)) / 3;
                pkt_words[w] = {pkt_words[w][15:0], b};
            end
            if (pkt_count != CountMax) pkt_count = pkt_count + 5'd1;
        end else begin
            // length beats type, type beats checksum
            if (pkt_count != CsumIndex) want.error_code = ERR_LENGTH;
            else if (!pkt_type_ok) want.error_code = ERR_TYPE;
            else if (8'(CsumSeed - pkt_sum) != b) want.error_code = ERR_CSUM;
            else want.error_code = ERR_OK;
            want.pose_valid = (want.error_code == ERR_OK);
            want.camera_num = want.pose_valid ? pkt_camera : 8'h00;
            want.words      = want.pose_valid ? pkt_words : '0;
            pose_expect_q.push_back(want);
            pkt_count   = '0;
            pkt_sum     = '0;
            pkt_type_ok = 1'b0;
            pkt_camera  = '0;
            pkt_words   = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in pose item %0d, %s: got 0x%0h, want 0x%0h",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // Fill patterns: 0 random, 1 all zeros, 2 all ones, 3 signed extremes per word.
    task automatic queue_packet(input int len, input logic [7:0] type_byte,
                                input int fill, input bit bad_csum);
        t_byte_item it;
        logic [7:0] sum;
        logic [7:0] b;
        int i;
        int f;
        sum = '0;
        for (i = 0; i < len; i++) begin
            if (i == 0) begin
                b = type_byte;
            end else if (len == PacketBytes && i == PacketBytes - 1) begin
                b = 8'(CsumSeed - sum) ^ (bad_csum ? 8'($urandom_range(1, 255)) : 8'h00);
            end else begin
                case (fill)
                    1: b = 8'h00;
                    2: b = 8'hFF;
                    3: begin
                        f = (i - 2) / 3;
                        if (i < 2 || i >= 26) b = 8'h5A;
                        else if ((i - 2) % 3 == 0) b = f[0] ? 8'h80 : 8'h7F;
                        else b = f[0] ? 8'h00 : 8'hFF;
                    end
                    default: b = 8'($urandom_range(0, 255));
                endcase
            end
            if (i < PacketBytes - 1) sum = sum + b;
            it.data_byte = b;
            it.end_of_packet = (i == len - 1);
            byte_q.push_back(it);
        end
    endtask

    // Mostly well-formed packets with random content; the rest are broken ones.
    task automatic run_random(input int nbytes);
        int left;
        int r;
        int len;
        left = nbytes;
        while (left > 0) begin
            r = $urandom_range(0, 99);
            len = PacketBytes;
            if (r < 72) begin
                queue_packet(len, type_cfg, 0, 1'b0);
            end else if (r < 80) begin
                queue_packet(len, type_cfg ^ 8'($urandom_range(1, 255)), 0, 1'b0);
            end else if (r < 88) begin
                queue_packet(len, type_cfg, 0, 1'b1);
            end else begin
                len = $urandom_range(1, 40);
                queue_packet(len, $urandom_range(0, 1) ? type_cfg : 8'($urandom_range(0, 255)),
                             0, $urandom_range(0, 1));
            end
            left -= len;
        end
    endtask

    // Hold until every byte is in and every pose item is out, then let the block settle.
    task automatic wait_drained();
        while (byte_q.size() != 0 || s_tvalid || pose_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_type(input logic [7:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        type_cfg = value;
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Byte driver: offer the next queued byte when the slot is free, idling at random.
    always @(posedge i_clk) begin : drive_bytes
        t_byte_item nxt;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_axis_tready) track_packet_byte(s_tdata, s_tlast);
            if (!s_tvalid || o_s_axis_tready) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                    nxt = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data_byte;
                    s_tlast  <= nxt.end_of_packet;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Pose receiver: random back-pressure, plus a long hold-off on request.
    always @(posedge i_clk) begin : drive_ready
        int hold_left;
        int hold_seen;
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HoldCycles;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Check each pose item against the oldest one owed.
    always @(posedge i_clk) begin : check_pose
        t_pose_expect want;
        int j;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            result_count++;
            if (pose_expect_q.size() == 0) begin
                report_mismatch("item with none owed", 32'(o_m_axis_tuser), 32'h0);
            end else begin
                want = pose_expect_q.pop_front();
                if (o_m_axis_tuser[0] !== want.pose_valid)
                    report_mismatch("pose_valid", 32'(o_m_axis_tuser[0]), 32'(want.pose_valid));
                if (o_m_axis_tuser[2:1] !== want.error_code)
                    report_mismatch("error_code", 32'(o_m_axis_tuser[2:1]),
                                    32'(want.error_code));
                if (o_m_axis_tdata[7:0] !== want.camera_num)
                    report_mismatch("camera_num", 32'(o_m_axis_tdata[7:0]),
                                    32'(want.camera_num));
                for (j = 0; j < FieldCount; j++) begin
                    if (o_m_axis_tdata[8 + 24 * j +: 24] !== want.words[j])
                        report_mismatch(word_name[j], 32'(o_m_axis_tdata[8 + 24 * j +: 24]),
                                        32'(want.words[j]));
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves an item for too long.
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)
            || (cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet == QuietLimit) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed packets under the reset type value.
        queue_packet(PacketBytes, type_cfg, 1, 1'b0);
        queue_packet(PacketBytes, type_cfg, 2, 1'b0);
        queue_packet(PacketBytes, type_cfg, 3, 1'b0);
        queue_packet(1, type_cfg, 0, 1'b0);
        queue_packet(PacketBytes - 1, type_cfg, 0, 1'b0);
        queue_packet(PacketBytes, ~type_cfg, 0, 1'b0);
        queue_packet(PacketBytes, type_cfg, 0, 1'b1);
        queue_packet(PacketBytes + 1, type_cfg, 0, 1'b0);
        // long enough that a wrapping count would land on the checksum index
        queue_packet(61, type_cfg, 0, 1'b0);
        queue_packet(20, ~type_cfg, 0, 1'b1);
        queue_packet(PacketBytes, ~type_cfg, 0, 1'b1);
        queue_packet(PacketBytes, type_cfg, 0, 1'b0);

        write_type(8'h00);
        queue_packet(PacketBytes, type_cfg, 2, 1'b0);
        run_random(200);

        // stretch with no idling on either side
        write_type(8'hFF);
        idle_pct <= 0;
        queue_packet(PacketBytes, type_cfg, 1, 1'b0);
        run_random(200);
        wait_drained();
        idle_pct <= IdlePctBusy;

        // long receiver hold-off while short packets keep coming
        hold_req <= hold_req + 1;
        repeat (40) queue_packet($urandom_range(1, 3), type_cfg, 0, 1'b0);
        run_random(100);

        // let the sender pause until everything is out, then go on
        wait_drained();
        run_random(100);

        write_type(8'($urandom_range(1, 254)));
        run_random(170);

        write_type(TypeDefault);
        run_random(200);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- camera_pose_packet_parser.f -----
sv/cpp_pkg.sv
sv/cpp_in_stage.sv
sv/cpp_core.sv
sv/cpp_out_stage.sv
sv/camera_pose_packet_parser.sv
tb/tb.sv
